/* design/dfs_pkg.sv */
package dfs_pkg;

   localparam logic [1:0] CMD_ADD_EDGE = 2'd0;
   localparam logic [1:0] CMD_RUN      = 2'd1;
   localparam logic [1:0] CMD_CLEAR    = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_OUT_RANGE = 2'd2;

   // datapath commands from the controller
   typedef struct packed {
      logic add_edge;     // append request edge, issue status
      logic clear_edges;  // empty the edge store
      logic run_start;    // clear marks, root at zero
      logic root_check;   // root visited test done, maybe push root
      logic root_next;    // advance root
      logic scan_eval;    // evaluate read edge
      logic pop;          // pop top frame, record finish
      logic emit_start;   // begin emission
      logic emit_put;     // present vertex on output
   } dfs_cmd_type;

   typedef struct packed {
      logic roots_done;   // root reached vertex count
      logic root_visited;
      logic stack_empty;
      logic scan_end;     // top frame position reached edges stored
      logic emit_done;    // all finished vertices emitted
      logic out_busy;     // output register holds an untaken transaction
   } dfs_status_type;

endpackage

/* design/dfs_topological_sort.sv */
// Depth-first topological sort engine.
// Input channel (req_*): one transaction carries cmd, src_vertex, dst_vertex.
//   cmd add edge appends src->dst to the edge store and returns one status
//   transaction (last=1). cmd run walks the graph depth first from vertex 0
//   upward and returns one transaction per finished vertex in reverse finish
//   order, last=1 on the final one. cmd clear empties the edge store, no result.
// Result channel (rsp_*): vertex, last, status, held in an output register;
//   while rsp_stall is high the register holds and req_stall rises.
// Configuration: csr_write loads csr_vertex_count (vertices in use); the user
//   writes it only while idle, the block does not enforce this. An add edge
//   answers in the cycle after acceptance, one per cycle while rsp_stall is
//   low. A run reads the edges of each stack frame serially from the edge
//   memory. No new transaction is taken during a run.
// Reset: synchronous, clears the edge count, sets the vertex count to 64 and
//   empties the output register. Edge memory contents need no clearing.
module dfs_topological_sort #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES    = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [5:0] req_src_vertex,
   input  logic [5:0] req_dst_vertex,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [5:0] rsp_vertex,
   output logic       rsp_last,
   output logic [1:0] rsp_status,
   input  logic       csr_write,
   input  logic [6:0] csr_vertex_count
);
   import dfs_pkg::*;

   dfs_cmd_type    cmd;
   dfs_status_type sts;

   // sequencing: accept, walk stack, emit
   dfs_controller u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_cmd, .sts, .cmd);

   // edge store, frame stack, visited marks, finish order, output register
   dfs_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
      .clock, .reset, .csr_write, .csr_vertex_count, .req_src_vertex,
      .req_dst_vertex, .cmd, .sts, .rsp_valid, .rsp_stall, .rsp_vertex,
      .rsp_last, .rsp_status);
endmodule

/* design/dfs_ram.sv */
module dfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* design/dfs_datapath.sv */
module dfs_datapath #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES    = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [6:0]             csr_vertex_count,
   input  logic [5:0]             req_src_vertex,
   input  logic [5:0]             req_dst_vertex,
   input  dfs_pkg::dfs_cmd_type    cmd,
   output dfs_pkg::dfs_status_type sts,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [5:0]             rsp_vertex,
   output logic                   rsp_last,
   output logic [1:0]             rsp_status
);
   import dfs_pkg::*;

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int EW = $clog2(MAX_EDGES);
   localparam int CW = $clog2(MAX_EDGES + 1);
   localparam int DW = $clog2(MAX_VERTICES + 1);

   logic [6:0]  vcount_ff;
   logic [6:0]  nact;
   logic [CW-1:0] edges_ff;
   logic [MAX_VERTICES-1:0] visited_ff;
   logic [DW-1:0] depth_ff;
   logic [DW-1:0] done_ff;
   logic [DW-1:0] root_ff;
   logic [DW-1:0] emit_ff;
   logic [VW-1:0] top_v_ff;
   logic [CW-1:0] top_e_ff;
   logic        out_valid_ff;
   logic [5:0]  out_vertex_ff;
   logic        out_last_ff;
   logic [1:0]  out_status_ff;

   // frame stack memory
   logic          stk_we;
   logic [VW-1:0] stk_waddr;
   logic [VW+CW-1:0] stk_wdata;
   logic [VW-1:0] stk_raddr;
   logic [VW+CW-1:0] stk_rdata;

   logic [5:0] esrc_rd;
   logic [5:0] edst_rd;
   logic       edge_we;
   logic [VW-1:0] fin_rd;
   logic [VW-1:0] fin_raddr;

   logic [6:0] src_ext;
   logic [6:0] dst_ext;
   logic       push_ok;

   assign nact = (vcount_ff > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vcount_ff;
   assign src_ext = {1'b0, req_src_vertex};
   assign dst_ext = {1'b0, req_dst_vertex};
   assign edge_we = cmd.add_edge && src_ext < nact && dst_ext < nact
                    && edges_ff < CW'(MAX_EDGES);

   dfs_ram #(.WIDTH(6), .DEPTH(MAX_EDGES)) u_src_ram (
      .clock, .wr_en(edge_we), .wr_addr(edges_ff[EW-1:0]), .wr_data(req_src_vertex),
      .rd_addr(top_e_ff[EW-1:0]), .rd_data(esrc_rd));
   dfs_ram #(.WIDTH(6), .DEPTH(MAX_EDGES)) u_dst_ram (
      .clock, .wr_en(edge_we), .wr_addr(edges_ff[EW-1:0]), .wr_data(req_dst_vertex),
      .rd_addr(top_e_ff[EW-1:0]), .rd_data(edst_rd));

   dfs_ram #(.WIDTH(VW+CW), .DEPTH(MAX_VERTICES)) u_stack_ram (
      .clock, .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
      .rd_addr(stk_raddr), .rd_data(stk_rdata));

   dfs_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_fin_ram (
      .clock, .wr_en(cmd.pop && done_ff < DW'(MAX_VERTICES)),
      .wr_addr(done_ff[VW-1:0]), .wr_data(top_v_ff),
      .rd_addr(fin_raddr), .rd_data(fin_rd));

   assign fin_raddr = VW'(done_ff - DW'(1) - emit_ff);

   // edge evaluation against the top frame
   logic hit;
   logic [VW-1:0] dst_v;
   assign dst_v = edst_rd[VW-1:0];
   assign hit = (esrc_rd[VW-1:0] == top_v_ff) && ({1'b0, edst_rd} < nact)
                && !visited_ff[dst_v];
   assign push_ok = depth_ff < DW'(MAX_VERTICES);

   // stack write: save caller frame position on push; a new root frame is not written
   always_comb begin
      stk_we    = 1'b0;
      stk_waddr = '0;
      stk_wdata = '0;
      if (cmd.root_check && !visited_ff[root_ff[VW-1:0]]) begin
         stk_we    = 1'b0;
      end else if (cmd.scan_eval && hit && push_ok) begin
         stk_we    = 1'b1;
         stk_waddr = VW'(depth_ff - DW'(1));
         stk_wdata = {top_v_ff, top_e_ff + CW'(1)};
      end
   end
   // on pop the new top is read from depth-2
   assign stk_raddr = VW'(depth_ff - DW'(2));

   assign sts.roots_done   = root_ff >= DW'(nact);
   assign sts.root_visited = visited_ff[root_ff[VW-1:0]];
   assign sts.stack_empty  = depth_ff == '0;
   assign sts.scan_end     = top_e_ff >= edges_ff;
   assign sts.emit_done    = emit_ff >= done_ff;
   assign sts.out_busy     = out_valid_ff && rsp_stall;

   logic popped_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= 7'd64;
         edges_ff     <= '0;
         depth_ff     <= '0;
         out_valid_ff <= 1'b0;
         popped_ff    <= 1'b0;
      end else begin
         if (csr_write) vcount_ff <= csr_vertex_count;
         // load a new transaction, else drop the one just taken
         if (cmd.add_edge || cmd.emit_put) begin
            out_valid_ff <= 1'b1;
         end else if (out_valid_ff && !rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         popped_ff <= cmd.pop;
         if (edge_we) edges_ff <= edges_ff + CW'(1);
         if (cmd.clear_edges) edges_ff <= '0;
         if (cmd.add_edge) begin
            out_vertex_ff <= '0;
            out_last_ff   <= 1'b1;
            out_status_ff <= (src_ext >= nact || dst_ext >= nact) ? STATUS_OUT_RANGE :
                             (edges_ff >= CW'(MAX_EDGES)) ? STATUS_FULL : STATUS_OK;
         end
         if (cmd.run_start) begin
            visited_ff <= '0;
            depth_ff   <= '0;
            done_ff    <= '0;
            root_ff    <= '0;
         end
         if (cmd.root_check && !visited_ff[root_ff[VW-1:0]]) begin
            visited_ff[root_ff[VW-1:0]] <= 1'b1;
            depth_ff <= DW'(1);
            top_v_ff <= root_ff[VW-1:0];
            top_e_ff <= '0;
         end
         if (cmd.root_next) root_ff <= root_ff + DW'(1);
         if (cmd.scan_eval) begin
            if (hit) begin
               if (push_ok) begin
                  visited_ff[dst_v] <= 1'b1;
                  depth_ff <= depth_ff + DW'(1);
                  top_v_ff <= dst_v;
                  top_e_ff <= '0;
               end else begin
                  top_e_ff <= top_e_ff + CW'(1);
               end
            end else begin
               top_e_ff <= top_e_ff + CW'(1);
            end
         end
         if (cmd.pop) begin
            depth_ff  <= depth_ff - DW'(1);
            if (done_ff < DW'(MAX_VERTICES)) done_ff <= done_ff + DW'(1);
         end
         // restore caller frame in the cycle after a pop (registered read)
         if (popped_ff && depth_ff != '0) begin
            top_v_ff <= stk_rdata[VW+CW-1:CW];
            top_e_ff <= stk_rdata[CW-1:0];
         end
         if (cmd.emit_start) emit_ff <= '0;
         if (cmd.emit_put) begin
            out_vertex_ff <= 6'(fin_rd);
            out_last_ff   <= (emit_ff + DW'(1)) == done_ff;
            out_status_ff <= STATUS_OK;
            emit_ff       <= emit_ff + DW'(1);
         end
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_vertex = out_vertex_ff;
   assign rsp_last   = out_last_ff;
   assign rsp_status = out_status_ff;
endmodule

/* design/dfs_controller.sv */
module dfs_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_cmd,
   input  dfs_pkg::dfs_status_type sts,
   output dfs_pkg::dfs_cmd_type    cmd
);
   import dfs_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_ROOT   = 4'd1;
   localparam logic [3:0] S_READ   = 4'd2;
   localparam logic [3:0] S_WAIT   = 4'd3;
   localparam logic [3:0] S_EVAL   = 4'd4;
   localparam logic [3:0] S_POPW   = 4'd5;
   localparam logic [3:0] S_EMIT   = 4'd6;
   localparam logic [3:0] S_ELOAD  = 4'd7;
   localparam logic [3:0] S_EPUT   = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE) || sts.out_busy;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_ADD_EDGE: begin
                     cmd.add_edge = 1'b1;
                  end
                  CMD_CLEAR: begin
                     cmd.clear_edges = 1'b1;
                  end
                  CMD_RUN: begin
                     cmd.run_start = 1'b1;
                     state_in = S_ROOT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ROOT: begin
            if (sts.roots_done) begin
               state_in = S_EMIT;
            end else begin
               cmd.root_check = 1'b1;
               cmd.root_next  = 1'b1;
               state_in = sts.root_visited ? S_ROOT : S_READ;
            end
         end
         S_READ: begin
            if (sts.stack_empty) begin
               state_in = S_ROOT;
            end else if (sts.scan_end) begin
               cmd.pop  = 1'b1;
               state_in = S_POPW;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: state_in = S_EVAL;
         S_EVAL: begin
            cmd.scan_eval = 1'b1;
            state_in = S_READ;
         end
         S_POPW: state_in = S_READ;
         S_EMIT: begin
            cmd.emit_start = 1'b1;
            state_in = S_ELOAD;
         end
         S_ELOAD: begin
            if (sts.emit_done) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_EPUT;
            end
         end
         S_EPUT: begin
            if (!sts.out_busy) begin
               cmd.emit_put = 1'b1;
               state_in = S_ELOAD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
